### design/itoa_fmt_pkg.sv
// ----------------------------------------------------------------------------
// itoa_fmt_pkg
// Shared constants, control word layout and microcode table of the integer
// to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_fmt_pkg;

   // cell geometry
   localparam int CELL_BITS    = 32;
   localparam int VALUE_W      = 32;
   localparam int CELL_NIBBLES = (CELL_BITS + 3) / 4;
   localparam int MAG_W        = CELL_NIBBLES * 4;
   localparam int EXT_W        = (CELL_BITS > VALUE_W) ? CELL_BITS : VALUE_W;
   // decimal digits of 2^(CELL_BITS-1), 1233/4096 ~ log10(2)
   localparam int DEC_DIGITS   = ((CELL_BITS - 1) * 1233) / 4096 + 1;
   localparam int DIGITS       = (DEC_DIGITS > CELL_NIBBLES) ? DEC_DIGITS : CELL_NIBBLES;
   localparam int CNT_W        = $clog2(DIGITS + 1);
   localparam int IDX_W        = $clog2(DIGITS);
   localparam int UPC_W        = 3;

   // ascii codes
   localparam logic [7:0] CHR_ZERO    = 8'h30;
   localparam logic [7:0] CHR_X       = 8'h78;
   localparam logic [7:0] CHR_MINUS   = 8'h2d;
   localparam logic [7:0] CHR_LOWER_A = 8'h61;

   // microcode step addresses
   localparam logic [UPC_W-1:0] STEP_IDLE   = UPC_W'(0);
   localparam logic [UPC_W-1:0] STEP_CONV   = UPC_W'(1);
   localparam logic [UPC_W-1:0] STEP_COUNT  = UPC_W'(2);
   localparam logic [UPC_W-1:0] STEP_ZERO   = UPC_W'(3);
   localparam logic [UPC_W-1:0] STEP_X      = UPC_W'(4);
   localparam logic [UPC_W-1:0] STEP_PAD    = UPC_W'(5);
   localparam logic [UPC_W-1:0] STEP_SIGN   = UPC_W'(6);
   localparam logic [UPC_W-1:0] STEP_DIGITS = UPC_W'(7);

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_CONV,
      OP_COUNT,
      OP_PAD,
      OP_ND,
      OP_DEC
   } dp_op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_START,
      COND_CNT_GT1,
      COND_CNT_ZERO,
      COND_ND_ZERO,
      COND_NOT_HEX
   } cond_type;

   typedef enum logic [1:0] {
      EM_NO,
      EM_YES,
      EM_NEG
   } emit_type;

   typedef enum logic [1:0] {
      CH_ZERO,
      CH_X,
      CH_MINUS,
      CH_DIGIT
   } char_sel_type;

   typedef enum logic [1:0] {
      LAST_NONE,
      LAST_CNT1,
      LAST_PAD
   } last_sel_type;

   typedef struct packed {
      dp_op_type          op;
      cond_type           cond;
      logic [UPC_W-1:0]   target;
      emit_type           emit;
      char_sel_type       char_sel;
      last_sel_type       last_sel;
   } ctrl_word_type;

   typedef struct packed {
      logic cnt_gt1;
      logic cnt_zero;
      logic nd_zero;
      logic hex;
   } status_type;

   // control store: a false condition falls through to the next step,
   // the digit loop wraps back to idle
   function automatic ctrl_word_type ucode_rom(input logic [UPC_W-1:0] upc);
      ctrl_word_type w;
      w = '{op: OP_NONE, cond: COND_NEVER, target: STEP_IDLE, emit: EM_NO,
            char_sel: CH_ZERO, last_sel: LAST_NONE};
      unique case (upc)
         STEP_IDLE:   begin
            w.op     = OP_LOAD;
            w.cond   = COND_NO_START;
            w.target = STEP_IDLE;
         end
         STEP_CONV:   begin
            w.op     = OP_CONV;
            w.cond   = COND_CNT_GT1;
            w.target = STEP_CONV;
         end
         STEP_COUNT:  begin
            w.op     = OP_COUNT;
            w.cond   = COND_NOT_HEX;
            w.target = STEP_SIGN;
         end
         STEP_ZERO:   begin
            w.op       = OP_PAD;
            w.emit     = EM_YES;
            w.char_sel = CH_ZERO;
         end
         STEP_X:      begin
            w.cond     = COND_CNT_ZERO;
            w.target   = STEP_SIGN;
            w.emit     = EM_YES;
            w.char_sel = CH_X;
         end
         STEP_PAD:    begin
            w.op       = OP_DEC;
            w.cond     = COND_CNT_GT1;
            w.target   = STEP_PAD;
            w.emit     = EM_YES;
            w.char_sel = CH_ZERO;
            w.last_sel = LAST_PAD;
         end
         STEP_SIGN:   begin
            w.op       = OP_ND;
            w.cond     = COND_ND_ZERO;
            w.target   = STEP_IDLE;
            w.emit     = EM_NEG;
            w.char_sel = CH_MINUS;
         end
         STEP_DIGITS: begin
            w.op       = OP_DEC;
            w.cond     = COND_CNT_GT1;
            w.target   = STEP_DIGITS;
            w.emit     = EM_YES;
            w.char_sel = CH_DIGIT;
            w.last_sel = LAST_CNT1;
         end
      endcase
      return w;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHR_ZERO + {4'b0000, d};
      end else begin
         c = CHR_LOWER_A + {4'b0000, d} - 8'd10;
      end
      return c;
   endfunction

endpackage

### design/itoa_fmt_seq.sv
// ----------------------------------------------------------------------------
// itoa_fmt_seq
// Step counter and control store; evaluates the jump condition of each
// control word against datapath status.
// ----------------------------------------------------------------------------
module itoa_fmt_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  itoa_fmt_pkg::status_type    status,
   output itoa_fmt_pkg::ctrl_word_type ctrl,
   output logic                        busy
);

   logic [itoa_fmt_pkg::UPC_W-1:0] upc_ff;
   logic [itoa_fmt_pkg::UPC_W-1:0] upc_in;
   itoa_fmt_pkg::ctrl_word_type    word;
   logic                           take;

   always_comb begin
      word = itoa_fmt_pkg::ucode_rom(upc_ff);
      unique case (word.cond)
         itoa_fmt_pkg::COND_NEVER:    take = 1'b0;
         itoa_fmt_pkg::COND_NO_START: take = !start;
         itoa_fmt_pkg::COND_CNT_GT1:  take = status.cnt_gt1;
         itoa_fmt_pkg::COND_CNT_ZERO: take = status.cnt_zero;
         itoa_fmt_pkg::COND_ND_ZERO:  take = status.nd_zero;
         itoa_fmt_pkg::COND_NOT_HEX:  take = !status.hex;
         default:                     take = 1'b0;
      endcase
      upc_in = take ? word.target : upc_ff + itoa_fmt_pkg::UPC_W'(1);
      ctrl   = word;
      // load only on an accepted transaction
      if (word.op == itoa_fmt_pkg::OP_LOAD && !start) begin
         ctrl.op = itoa_fmt_pkg::OP_NONE;
      end
   end

   assign busy = (upc_ff != itoa_fmt_pkg::STEP_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= itoa_fmt_pkg::STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

### design/itoa_fmt_dp.sv
// ----------------------------------------------------------------------------
// itoa_fmt_dp
// Datapath: magnitude shifter, shift-and-add-3 digit register, significant
// digit mask, shared count register and registered character output.
// ----------------------------------------------------------------------------
module itoa_fmt_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  itoa_fmt_pkg::ctrl_word_type           ctrl,
   input  logic                                  req_op,
   input  logic signed [itoa_fmt_pkg::VALUE_W-1:0] req_value,
   output itoa_fmt_pkg::status_type              status,
   output logic                                  rsp_strobe,
   output logic [7:0]                            rsp_char_code,
   output logic                                  rsp_last
);

   localparam int DIGITS = itoa_fmt_pkg::DIGITS;
   localparam int CNT_W  = itoa_fmt_pkg::CNT_W;
   localparam int IDX_W  = itoa_fmt_pkg::IDX_W;
   localparam int MAG_W  = itoa_fmt_pkg::MAG_W;
   localparam int CB     = itoa_fmt_pkg::CELL_BITS;

   logic                       hex_ff, hex_in;
   logic                       neg_ff, neg_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic [DIGITS-1:0][3:0]     bcd_ff, bcd_in;
   logic [DIGITS-1:0]          sig_ff, sig_in;
   logic [CNT_W-1:0]           nd_ff, nd_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]                 rsp_char_ff, rsp_char_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [itoa_fmt_pkg::EXT_W-1:0] ext_value;
   logic [CB-1:0]              cell_word;
   logic [CB-1:0]              mag_abs;
   logic [3:0]                 nib;
   logic [DIGITS-1:0][3:0]     bcd_conv;
   logic [DIGITS-1:0]          nz;
   logic [DIGITS-1:0]          sig_conv;
   logic [CNT_W-1:0]           sig_count;
   logic [CNT_W-1:0]           cnt_m1;
   logic [3:0]                 digit;
   logic                       emit;

   // sign extend, then reduce to the cell
   always_comb begin
      ext_value = itoa_fmt_pkg::EXT_W'(req_value);
      cell_word = ext_value[CB-1:0];
      mag_abs   = cell_word[CB-1] ? (~cell_word + CB'(1)) : cell_word;
   end

   // four shift steps per cycle; add-3 correction only in decimal
   always_comb begin
      nib      = mag_ff[MAG_W-1 -: 4];
      bcd_conv = bcd_ff;
      for (int b = 3; b >= 0; b--) begin
         if (!hex_ff) begin
            for (int i = 0; i < DIGITS; i++) begin
               if (bcd_conv[i] >= 4'd5) begin
                  bcd_conv[i] = bcd_conv[i] + 4'd3;
               end
            end
         end
         bcd_conv = (DIGITS * 4)'({bcd_conv, nib[b]});
      end
      for (int i = 0; i < DIGITS; i++) begin
         nz[i] = (bcd_conv[i] != 4'd0);
      end
      // value grows by at most two digits a cycle, so the mask stays a thermometer
      sig_conv  = sig_ff | nz | {1'b0, nz[DIGITS-1:1]};
      sig_count = CNT_W'($countones(sig_ff));
      cnt_m1    = cnt_ff - CNT_W'(1);
      digit     = bcd_ff[cnt_m1[IDX_W-1:0]];
   end

   always_comb begin
      hex_in = hex_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      sig_in = sig_ff;
      nd_in  = nd_ff;
      cnt_in = cnt_ff;
      unique case (ctrl.op)
         itoa_fmt_pkg::OP_LOAD: begin
            hex_in = req_op;
            neg_in = cell_word[CB-1];
            mag_in = MAG_W'(mag_abs);
            bcd_in = '0;
            sig_in = '0;
            cnt_in = CNT_W'(itoa_fmt_pkg::CELL_NIBBLES);
         end
         itoa_fmt_pkg::OP_CONV: begin
            mag_in = {mag_ff[MAG_W-5:0], 4'h0};
            bcd_in = bcd_conv;
            sig_in = sig_conv;
            cnt_in = cnt_m1;
         end
         itoa_fmt_pkg::OP_COUNT: begin
            // decimal zero still prints one digit
            nd_in = (sig_count == '0 && !hex_ff) ? CNT_W'(1) : sig_count;
         end
         itoa_fmt_pkg::OP_PAD: begin
            cnt_in = CNT_W'(itoa_fmt_pkg::CELL_NIBBLES) - nd_ff;
         end
         itoa_fmt_pkg::OP_ND: begin
            cnt_in = nd_ff;
         end
         itoa_fmt_pkg::OP_DEC: begin
            cnt_in = cnt_m1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      unique case (ctrl.emit)
         itoa_fmt_pkg::EM_YES: emit = 1'b1;
         itoa_fmt_pkg::EM_NEG: emit = neg_ff;
         default:              emit = 1'b0;
      endcase
      unique case (ctrl.char_sel)
         itoa_fmt_pkg::CH_ZERO:  rsp_char_in = itoa_fmt_pkg::CHR_ZERO;
         itoa_fmt_pkg::CH_X:     rsp_char_in = itoa_fmt_pkg::CHR_X;
         itoa_fmt_pkg::CH_MINUS: rsp_char_in = itoa_fmt_pkg::CHR_MINUS;
         default:                rsp_char_in = itoa_fmt_pkg::digit_char(digit);
      endcase
      unique case (ctrl.last_sel)
         itoa_fmt_pkg::LAST_CNT1: rsp_last_in = (cnt_ff == CNT_W'(1));
         itoa_fmt_pkg::LAST_PAD:  rsp_last_in = (cnt_ff == CNT_W'(1)) && (nd_ff == '0);
         default:                 rsp_last_in = 1'b0;
      endcase
      rsp_strobe_in = emit;
      rsp_last_in   = rsp_last_in && emit;
   end

   always_comb begin
      status.cnt_gt1  = (cnt_ff > CNT_W'(1));
      status.cnt_zero = (cnt_ff == '0);
      status.nd_zero  = (nd_ff == '0);
      status.hex      = hex_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_ff        <= '0;
         cnt_ff        <= '0;
         nd_ff         <= '0;
         hex_ff        <= 1'b0;
         neg_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         sig_ff        <= sig_in;
         cnt_ff        <= cnt_in;
         nd_ff         <= nd_in;
         hex_ff        <= hex_in;
         neg_ff        <= neg_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

   a_last_has_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_last_ff |-> rsp_strobe_ff)
      else $error("last flag without strobe");

   a_sig_thermometer : assert property (@(posedge clock) disable iff (reset)
      (sig_ff[DIGITS-1:1] & ~sig_ff[DIGITS-2:0]) == '0)
      else $error("significant digit mask has a hole");

   a_digit_index : assert property (@(posedge clock) disable iff (reset)
      (ctrl.char_sel == itoa_fmt_pkg::CH_DIGIT && ctrl.emit == itoa_fmt_pkg::EM_YES)
      |-> (cnt_ff != '0 && cnt_ff <= CNT_W'(DIGITS)))
      else $error("digit read outside digit register");

endmodule

### design/integer_to_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Prints a signed cell-width integer as ASCII, decimal or 0x-prefixed hex.
// ----------------------------------------------------------------------------
// A transaction is taken at a clock edge with start high and busy low;
// req_op selects the format (0 decimal, 1 hex) and req_value the number.
// Characters leave most significant first, one per cycle at most, each shown
// for one cycle with rsp_strobe high; rsp_last marks the final character.
// The receiver cannot stall: every strobed character must be taken.
// A small microcode program steps the datapath. Conversion shifts four
// magnitude bits a cycle into a digit register, then a count step tallies the
// significant digits, then the characters follow, at most one per step; the
// sign step emits nothing for a non-negative number. The last character of a
// decimal or of a nonzero hex number shows while busy is already low, when a
// new transaction can already be taken.
// Synchronous reset returns the sequencer to idle and drops any output.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_op,
   input  logic signed [itoa_fmt_pkg::VALUE_W-1:0] req_value,
   output logic                                    rsp_strobe,
   output logic [7:0]                              rsp_char_code,
   output logic                                    rsp_last
);

   itoa_fmt_pkg::ctrl_word_type ctrl;
   itoa_fmt_pkg::status_type    status;

   itoa_fmt_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   itoa_fmt_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .req_op        (req_op),
      .req_value     (req_value),
      .status        (status),
      .rsp_strobe    (rsp_strobe),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_strobe_in_work : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("character strobed while idle");

endmodule

### bench/integer_to_ascii_formatter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit_tb
// Drives signed numbers in decimal and hex format through the formatter and
// checks every emitted character and its last flag against directed text or a
// local model of the printing rules. A short table of directed numbers comes
// first, then random numbers of mixed shapes with random gaps between them.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit_tb;

   localparam logic FMT_DEC        = 1'b0;
   localparam logic FMT_HEX        = 1'b1;
   localparam int   DIRECTED_N     = 22;
   localparam int   RANDOM_N       = 198;
   localparam int   WATCHDOG_LIMIT = 4000;
   localparam int   TAIL_CYCLES    = 40;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } char_item_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_op = FMT_DEC;
   logic signed [itoa_fmt_pkg::VALUE_W-1:0] req_value = '0;
   logic                       rsp_strobe;
   logic [7:0]                 rsp_char_code;
   logic                       rsp_last;

   char_item_type expected_chars[$];
   int            mismatch_count = 0;
   int            idle_cycles = 0;

   // directed numbers; an empty string means the local model supplies the text
   logic        dir_op [DIRECTED_N] = '{
      FMT_DEC, FMT_HEX, FMT_DEC, FMT_HEX, FMT_DEC, FMT_HEX, FMT_DEC, FMT_HEX,
      FMT_DEC, FMT_HEX, FMT_DEC, FMT_DEC, FMT_DEC, FMT_HEX, FMT_HEX, FMT_HEX,
      FMT_HEX, FMT_DEC, FMT_DEC, FMT_HEX, FMT_HEX, FMT_DEC};
   logic [31:0] dir_value [DIRECTED_N] = '{
      32'h00000000, 32'h00000000, 32'h80000000, 32'h80000000,
      32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'hffffffff,
      32'h00000001, 32'h00000001, 32'd9, 32'd10,
      -32'sd10, 32'h0000000f, 32'h00000010, -32'sh10,
      32'h0000abcd, 32'd1000000000, -32'sd999999999, 32'h12345678,
      32'h80000001, 32'd123456789};
   string       dir_text [DIRECTED_N] = '{
      "0", "0x00000000", "-2147483648", "0x-80000000",
      "2147483647", "0x7fffffff", "-1", "0x0000000-1",
      "1", "0x00000001", "", "",
      "", "", "", "",
      "", "", "", "",
      "", ""};

   integer_to_ascii_formatter_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // queue the characters one number should print
   function automatic void render_number(input logic fmt, input logic [31:0] value);
      string         digit_set;
      logic [63:0]   wide;
      logic [63:0]   mask;
      logic [63:0]   cell_word;
      logic [63:0]   mag;
      logic          neg;
      logic [7:0]    digits[$];
      logic [7:0]    text[$];
      int            base;
      char_item_type item;
      digit_set = "0123456789abcdef";
      wide = {{32{value[31]}}, value};
      mask = (itoa_fmt_pkg::CELL_BITS >= 64) ? '1
                                             : ((64'd1 << itoa_fmt_pkg::CELL_BITS) - 64'd1);
      cell_word = wide & mask;
      neg  = cell_word[itoa_fmt_pkg::CELL_BITS-1];
      mag  = neg ? ((~cell_word + 64'd1) & mask) : cell_word;
      base = (fmt == FMT_HEX) ? 16 : 10;
      if (fmt == FMT_HEX) begin
         text.push_back("0");
         text.push_back("x");
      end
      if (cell_word == 0) begin
         if (fmt == FMT_HEX) begin
            for (int k = 0; k < itoa_fmt_pkg::CELL_NIBBLES; k++) text.push_back("0");
         end else begin
            text.push_back("0");
         end
      end else begin
         while (mag != 0) begin
            digits.push_front(digit_set[int'(mag % base)]);
            mag = mag / base;
         end
         if (fmt == FMT_HEX) begin
            for (int k = digits.size(); k < itoa_fmt_pkg::CELL_NIBBLES; k++) begin
               text.push_back("0");
            end
         end
         if (neg) text.push_back("-");
         foreach (digits[k]) text.push_back(digits[k]);
      end
      foreach (text[k]) begin
         item.code = text[k];
         item.last = (k == text.size() - 1);
         expected_chars.push_back(item);
      end
   endfunction

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $realtime, what);
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // one transaction: optional pause, then hold start until busy is low
   task automatic issue_number(input logic fmt, input logic [31:0] value,
                               input string text, input int gap, input bit drain);
      char_item_type item;
      if (gap > 0 || drain) begin
         start <= 1'b0;
         do @(posedge clock); while (drain && expected_chars.size() != 0);
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_op    <= fmt;
      req_value <= value;
      do @(posedge clock); while (busy);
      if (text.len() > 0) begin
         for (int k = 0; k < text.len(); k++) begin
            item.code = text[k];
            item.last = (k == text.len() - 1);
            expected_chars.push_back(item);
         end
      end else begin
         render_number(fmt, value);
      end
   endtask

   // results cannot be held off, so every strobe is checked as it appears
   always @(posedge clock) begin
      char_item_type want;
      if (!reset && rsp_strobe) begin
         if (expected_chars.size() == 0) begin
            note_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                    rsp_char_code, rsp_last));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_char_code !== want.code)
               note_mismatch($sformatf("char expected 0x%02h actual 0x%02h",
                                       want.code, rsp_char_code));
            if (rsp_last !== want.last)
               note_mismatch($sformatf("last expected %0b actual %0b",
                                       want.last, rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("integer_to_ascii_formatter_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int          shape;
      int          burst_left;
      int unsigned pow10;
      logic [31:0] v;
      logic        fmt;
      burst_left = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_N; i++) begin
         issue_number(dir_op[i], dir_value[i], dir_text[i], pick_gap(), 1'b0);
      end

      for (int i = 0; i < RANDOM_N; i++) begin
         fmt   = 1'($urandom_range(0, 1));
         shape = $urandom_range(0, 5);
         case (shape)
            1: begin
               v = $urandom_range(0, 40) - 20;
            end
            2: begin
               v = $urandom >> $urandom_range(0, 31);
               if ($urandom_range(0, 1)) v = -v;
            end
            3: begin
               // decimal digit-count boundaries
               pow10 = 1;
               repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
               v = pow10 + $urandom_range(0, 2) - 1;
               if ($urandom_range(0, 1)) v = -v;
            end
            4: begin
               v = $urandom_range(0, 1) ? 32'h80000000 + $urandom_range(0, 3)
                                        : 32'h7fffffff - $urandom_range(0, 3);
            end
            default: begin
               v = $urandom;
            end
         endcase
         if (burst_left == 0 && $urandom_range(0, 7) == 0) burst_left = $urandom_range(8, 15);
         if (burst_left > 0) begin
            burst_left--;
            issue_number(fmt, v, "", 0, (i % 40) == 39);
         end else begin
            issue_number(fmt, v, "", pick_gap(), (i % 40) == 39);
         end
      end

      start <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("integer_to_ascii_formatter_unit verification clean");
      end else begin
         $display("integer_to_ascii_formatter_unit verification failed");
      end
      $finish;
   end

endmodule
